FILE: rtl/ipmm_pkg.sv
// Shared types and constants for the IPv4 prefix membership table.
package ipmm_pkg;

    localparam int ADDR_W   = 32;
    localparam int PLEN_W   = 6;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 9;

    localparam logic [ADDR_W-1:0] ADDR_ONES  = 32'hFFFF_FFFF;
    localparam logic [ADDR_W-1:0] ADDR_ZERO  = 32'h0000_0000;
    localparam logic [PLEN_W-1:0] PLEN_ZERO  = 6'd0;
    localparam logic [PLEN_W-1:0] PREFIX_MAX = 6'd32;

    // operation codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
        logic [PLEN_W-1:0] prefix_len;
    } t_in_beat;

    typedef struct packed {
        logic                matched;
        logic [STATUS_W-1:0] status;
        logic [USED_W-1:0]   entries_used;
    } t_out_beat;

    // table write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] net;
        logic [ADDR_W-1:0] mask;
    } t_tbl_wr;

    // table lookup status
    typedef struct packed {
        logic hit;
        logic full;
    } t_tbl_stat;

    // top len bits set; len above 32 gives all ones
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
        return ~(ADDR_ONES >> len);
    endfunction

endpackage

FILE: rtl/ipmm_table.sv
// Entry store with a parallel compare of one address against every held entry.
module ipmm_table
    import ipmm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_tbl_wr                              i_wr,
    input  logic [ADDR_W-1:0]                    i_lk_addr,
    output t_tbl_stat                            o_stat,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]   o_count
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [ADDR_W-1:0]        r_net  [TABLE_ENTRIES];
    logic [ADDR_W-1:0]        r_mask [TABLE_ENTRIES];
    logic [CNT_W-1:0]         r_count;
    logic [TABLE_ENTRIES-1:0] hit_vec;

    // entry write at the fill position; no reset, reads gated by the count
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_net[r_count[IDX_W-1:0]]  <= i_wr.net;
            r_mask[r_count[IDX_W-1:0]] <= i_wr.mask;
        end
    end

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_wr.en) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // one comparator per entry
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cmp
        assign hit_vec[g] = (CNT_W'(g) < r_count) &&
                            ((i_lk_addr & r_mask[g]) == r_net[g]);
    end

    assign o_stat.hit  = |hit_vec;
    assign o_stat.full = (r_count == CNT_W'(TABLE_ENTRIES));
    assign o_count     = r_count;

endmodule

FILE: rtl/ipv4_prefix_membership_match_top.sv
// Top level of the IPv4 prefix membership table: beat registers and item decode.
//
// Input channel (i_in_valid / o_in_stall / i_in_beat): one beat is either an add
// (func 0) that appends a network/prefix entry, or a query (func 1) that asks
// whether any held entry covers the address. Output channel (o_out_valid /
// i_out_stall / o_out_beat): exactly one result beat per input beat, in order.
// A beat is taken at a rising edge where valid is high and stall is low.
//
// A taken beat lands in the input register; it is decoded against the table and
// its result is loaded once the output register is free, visible on the output
// from then on. Throughput is one beat per cycle while the receiver does not
// stall; the path that sets it is the compare of the address against all
// entries plus the OR over their hits. An add updates the table at the same
// edge that loads its result, so the next beat already sees the new entry.
//
// Reset (synchronous, active low) empties both beat registers and sets the
// entry count to zero; entry contents are not cleared and are never read
// until written. When the receiver stalls, the result beat holds, the input
// register holds its beat, and o_in_stall rises once both are occupied.
module ipv4_prefix_membership_match_top
    import ipmm_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic             r_in_valid;
    t_in_beat         r_in;
    logic             r_out_valid;
    t_out_beat        r_out;
    t_out_beat        n_out;

    logic             adv;
    logic             in_take;
    logic             is_add;
    logic             add_legal;
    logic             add_ok;
    t_tbl_wr          tbl_wr;
    t_tbl_stat        tbl_stat;
    logic [CNT_W-1:0] tbl_count;
    logic [CNT_W-1:0] count_after;

    // handshake: result register frees when empty or taken
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !adv;

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_beat;
        end
    end

    // item decode
    assign is_add    = (r_in.func == FUNC_ADD);
    assign add_legal = (r_in.address != ADDR_ZERO) && (r_in.prefix_len != PLEN_ZERO) &&
                       (r_in.prefix_len <= PREFIX_MAX);
    assign add_ok    = is_add && add_legal && !tbl_stat.full;

    assign tbl_wr.en   = adv && add_ok;
    assign tbl_wr.net  = r_in.address;
    assign tbl_wr.mask = prefix_mask(r_in.prefix_len);

    ipmm_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_lk_addr (r_in.address),
        .o_stat    (tbl_stat),
        .o_count   (tbl_count)
    );

    // result beat
    assign count_after = tbl_count + CNT_W'(add_ok);

    always_comb begin
        n_out.matched      = !is_add && tbl_stat.hit;
        n_out.status       = STATUS_DONE;
        n_out.entries_used = USED_W'(count_after);
        if (is_add) begin
            if (!add_legal) begin
                n_out.status = STATUS_INVALID;
            end else if (tbl_stat.full) begin
                n_out.status = STATUS_FULL;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // a query leaves the entry count alone
    a_query_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !is_add |=> $stable(tbl_count))
        else $error("entry count changed on a query");

    // count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above capacity");

    // a refused add only when the table is at capacity
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == STATUS_FULL |-> tbl_stat.full)
        else $error("full status with room left");

    // a flagged add never reports a match
    a_status_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != STATUS_DONE |-> !r_out.matched)
        else $error("match reported on an add");

    // stall only while both beat registers are occupied
    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with a free register");

endmodule

FILE: verif/ipv4_prefix_membership_match_top_tb.sv
// Self-checking testbench for the IPv4 prefix membership table, with a table predictor.
module ipv4_prefix_membership_match_top_tb;
    import ipmm_pkg::*;

    localparam int TBL_DEPTH   = 256;
    localparam int RAND_ITEMS  = 1100;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PRINT_CAP   = 30;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_beat = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_beat;

    ipv4_prefix_membership_match_top #(
        .TABLE_ENTRIES(TBL_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat (o_out_beat)
    );

    always #5 i_clk = ~i_clk;

    // directed row: beat plus an optional hand-typed result
    typedef struct packed {
        t_in_beat  beat;
        logic      typed;
        t_out_beat want;
    } t_dir_row;

    t_dir_row  dir_rows[$];
    t_out_beat pending_results[$];

    // predictor copy of the entry table
    logic [ADDR_W-1:0] tbl_net[TBL_DEPTH];
    logic [PLEN_W-1:0] tbl_len[TBL_DEPTH];
    int                tbl_count = 0;

    int mismatches = 0;
    int cycle_cnt  = 0;
    int in_calm    = 0;
    int out_hold   = 0;
    int out_calm   = 0;
    int n_adds     = 0;
    int n_queries  = 0;
    int n_hits     = 0;
    int n_invalid  = 0;
    int n_full     = 0;

    // network mask with the top len bits set, len 1..32
    function automatic logic [ADDR_W-1:0] net_mask(input logic [PLEN_W-1:0] len);
        return 32'hFFFF_FFFF << (6'd32 - len);
    endfunction

    // apply one beat to the predictor table and return its result
    function automatic t_out_beat table_apply(input t_in_beat b);
        t_out_beat r;
        r = '0;
        r.status = STATUS_DONE;
        if (b.func == FUNC_ADD) begin
            if (b.address == ADDR_ZERO || b.prefix_len == PLEN_ZERO ||
                b.prefix_len > PREFIX_MAX) begin
                r.status = STATUS_INVALID;
            end else if (tbl_count >= TBL_DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                tbl_net[tbl_count] = b.address;
                tbl_len[tbl_count] = b.prefix_len;
                tbl_count++;
            end
        end else begin
            for (int i = 0; i < tbl_count; i++) begin
                if ((b.address & net_mask(tbl_len[i])) == tbl_net[i])
                    r.matched = 1'b1;
            end
        end
        r.entries_used = tbl_count[USED_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch @%0d: %s got 0x%0h want 0x%0h", cycle_cnt, what, got, want);
    endtask

    task automatic dir_row(input logic func, input logic [31:0] addr,
                           input logic [5:0] plen, input logic typed,
                           input logic m, input logic [1:0] st, input int used);
        t_dir_row row;
        row.beat.func         = func;
        row.beat.address      = addr;
        row.beat.prefix_len   = plen;
        row.typed             = typed;
        row.want.matched      = m;
        row.want.status       = st;
        row.want.entries_used = used[USED_W-1:0];
        dir_rows.push_back(row);
    endtask

    // idle length before the next input beat: mostly none or short
    function automatic int pick_gap();
        int r;
        if (in_calm > 0) begin
            in_calm--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3) begin
            in_calm = $urandom_range(30, 100);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // send one beat, predict it once it is taken
    task automatic drive_beat(input t_in_beat b, input logic typed, input t_out_beat want);
        int        gap;
        t_out_beat pred;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = table_apply(b);
        if (b.func == FUNC_ADD) n_adds++;
        else n_queries++;
        if (pred.matched) n_hits++;
        if (pred.status == STATUS_INVALID) n_invalid++;
        if (pred.status == STATUS_FULL) n_full++;
        pending_results.push_back(typed ? want : pred);
    endtask

    // random beat: mostly well-formed adds and queries aimed at held entries
    function automatic t_in_beat make_random_beat();
        t_in_beat          b;
        logic [ADDR_W-1:0] m;
        int                r;
        int                idx;
        int                len;
        b.prefix_len = PLEN_W'($urandom_range(0, 63));
        b.address    = $urandom;
        r = $urandom_range(99);
        if (r < 45) begin
            b.func = FUNC_ADD;
            r = $urandom_range(99);
            if (r < 82) begin
                len = ($urandom_range(99) < 4) ? $urandom_range(1, 7) : $urandom_range(8, 32);
                m = net_mask(PLEN_W'(len));
                b.prefix_len = PLEN_W'(len);
                b.address    = $urandom & m;
                if (b.address == ADDR_ZERO) b.address = m;
            end else if (r < 91) begin
                // host bits set: held but can never match
                len = $urandom_range(1, 31);
                m = net_mask(PLEN_W'(len));
                b.prefix_len = PLEN_W'(len);
                b.address = ($urandom & m) | ($urandom & ~m) |
                            (32'h1 << $urandom_range(0, 31 - len));
            end else if (r < 94) begin
                b.address = ADDR_ZERO;
            end else if (r < 97) begin
                b.prefix_len = PLEN_ZERO;
            end else begin
                b.prefix_len = PLEN_W'($urandom_range(33, 63));
            end
        end else begin
            b.func = FUNC_QUERY;
            r = $urandom_range(99);
            if (tbl_count > 0 && r < 70) begin
                idx = $urandom_range(0, tbl_count - 1);
                m = net_mask(tbl_len[idx]);
                b.address = tbl_net[idx] | ($urandom & ~m);
                // near miss: flip one network bit
                if (r >= 55)
                    b.address ^= 32'h1 << $urandom_range(32 - int'(tbl_len[idx]), 31);
            end
        end
        return b;
    endfunction

    // result stall pattern: short bursts, rare long holds, calm stretches
    always @(posedge i_clk) begin
        if (out_hold > 0) begin
            out_hold--;
        end else if (out_calm > 0) begin
            out_calm--;
        end else begin
            case ($urandom_range(99)) inside
                [0:4]:   out_calm = $urandom_range(30, 120);
                [5:59]:  out_hold = 0;
                [60:89]: out_hold = $urandom_range(1, 3);
                [90:97]: out_hold = $urandom_range(4, 12);
                default: out_hold = $urandom_range(20, 50);
            endcase
        end
        i_out_stall <= (out_hold > 0);
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, entries_used",
                                32'(o_out_beat.entries_used), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_beat.matched !== want.matched)
                    report_mismatch("matched", 32'(o_out_beat.matched), 32'(want.matched));
                if (o_out_beat.status !== want.status)
                    report_mismatch("status", 32'(o_out_beat.status), 32'(want.status));
                if (o_out_beat.entries_used !== want.entries_used)
                    report_mismatch("entries_used", 32'(o_out_beat.entries_used),
                                    32'(want.entries_used));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_out_beat no_want;
        no_want = '0;

        // empty table, invalid adds, extremes, host bits set, duplicates
        dir_row(FUNC_QUERY, 32'h0000_0000, 6'd0,  1'b1, 1'b0, STATUS_DONE,    0);
        dir_row(FUNC_QUERY, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, STATUS_DONE,    0);
        dir_row(FUNC_ADD,   32'h0000_0000, 6'd8,  1'b1, 1'b0, STATUS_INVALID, 0);
        dir_row(FUNC_ADD,   32'h0A00_0000, 6'd0,  1'b1, 1'b0, STATUS_INVALID, 0);
        dir_row(FUNC_ADD,   32'h0A00_0000, 6'd33, 1'b1, 1'b0, STATUS_INVALID, 0);
        dir_row(FUNC_ADD,   32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, STATUS_INVALID, 0);
        dir_row(FUNC_ADD,   32'h0000_0000, 6'd0,  1'b1, 1'b0, STATUS_INVALID, 0);
        dir_row(FUNC_ADD,   32'h0A00_0000, 6'd8,  1'b1, 1'b0, STATUS_DONE,    1);
        dir_row(FUNC_QUERY, 32'h0A12_3456, 6'd0,  1'b0, 1'b0, STATUS_DONE,    0);
        dir_row(FUNC_QUERY, 32'h0B00_0000, 6'd0,  1'b0, 1'b0, STATUS_DONE,    0);
        dir_row(FUNC_ADD,   32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, STATUS_DONE,    2);
        dir_row(FUNC_QUERY, 32'hFFFF_FFFF, 6'd32, 1'b0, 1'b0, STATUS_DONE,    0);
        dir_row(FUNC_QUERY, 32'hFFFF_FFFE, 6'd0,  1'b0, 1'b0, STATUS_DONE,    0);
        dir_row(FUNC_ADD,   32'h8000_0000, 6'd1,  1'b1, 1'b0, STATUS_DONE,    3);
        dir_row(FUNC_QUERY, 32'h8000_0001, 6'd0,  1'b0, 1'b0, STATUS_DONE,    0);
        dir_row(FUNC_QUERY, 32'h7FFF_FFFF, 6'd0,  1'b0, 1'b0, STATUS_DONE,    0);
        dir_row(FUNC_ADD,   32'hC0A8_01FF, 6'd24, 1'b1, 1'b0, STATUS_DONE,    4);
        dir_row(FUNC_QUERY, 32'hC0A8_01FF, 6'd0,  1'b0, 1'b0, STATUS_DONE,    0);
        dir_row(FUNC_ADD,   32'h0A00_0000, 6'd8,  1'b1, 1'b0, STATUS_DONE,    5);
        dir_row(FUNC_QUERY, 32'h0AFF_FFFF, 6'd63, 1'b0, 1'b0, STATUS_DONE,    0);
        dir_row(FUNC_ADD,   32'h0000_0001, 6'd32, 1'b1, 1'b0, STATUS_DONE,    6);
        dir_row(FUNC_QUERY, 32'h0000_0001, 6'd0,  1'b0, 1'b0, STATUS_DONE,    0);
        dir_row(FUNC_QUERY, 32'h0000_0000, 6'd0,  1'b0, 1'b0, STATUS_DONE,    0);
        dir_row(FUNC_ADD,   32'h0000_FF00, 6'd24, 1'b1, 1'b0, STATUS_DONE,    7);
        dir_row(FUNC_QUERY, 32'h0000_FF7F, 6'd0,  1'b0, 1'b0, STATUS_DONE,    0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            drive_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

        // random part; the table fills partway through, then adds are refused
        repeat (RAND_ITEMS)
            drive_beat(make_random_beat(), 1'b0, no_want);
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("covered %0d adds (%0d invalid, %0d refused full) and %0d queries (%0d hits)",
                 n_adds, n_invalid, n_full, n_queries, n_hits);
        $display("table held %0d of %0d entries, %0d mismatches",
                 tbl_count, TBL_DEPTH, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
